// ===== rtl/mpct_pkg.sv =====
package mpct_pkg;

  // Width of a cursor coordinate and of the configuration data.
  localparam int unsigned CoordBits = 12;

  // Bits of the controller status byte.
  localparam int unsigned StatusFullBit = 0;
  localparam int unsigned StatusAuxBit  = 5;

  // Bits of the packet header byte.
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;

  localparam logic [CoordBits-1:0] XLimitReset = CoordBits'(1010);
  localparam logic [CoordBits-1:0] YLimitReset = CoordBits'(754);
  localparam logic [CoordBits-1:0] XStartReset = CoordBits'(512);
  localparam logic [CoordBits-1:0] YStartReset = CoordBits'(384);

  typedef enum logic [7:0] {
    CfgXLimit = 8'd0,
    CfgYLimit = 8'd1,
    CfgXStart = 8'd2,
    CfgYStart = 8'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhHeader = 3'b001,
    PhXMove  = 3'b010,
    PhYMove  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] ctrl_status;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
    logic                 left_button;
  } out_t;

endpackage

// ===== rtl/mpct_axis_update.sv =====
module mpct_axis_update (
  input  logic [mpct_pkg::CoordBits-1:0] pos_i,
  input  logic [7:0]                     delta_i,
  input  logic                           sign_i,
  input  logic                           subtract_i,
  input  logic [mpct_pkg::CoordBits-1:0] limit_i,
  output logic [mpct_pkg::CoordBits-1:0] pos_o
);

  localparam int unsigned SumBits = mpct_pkg::CoordBits + 2;

  logic [SumBits-1:0] pos_ext;
  logic [SumBits-1:0] delta_ext;
  logic [SumBits-1:0] sum;
  logic               below_zero;
  logic               above_limit;

  // The movement is a 9-bit two's complement value: sign bit above the byte.
  assign pos_ext   = {2'b00, pos_i};
  assign delta_ext = {{(SumBits-8){sign_i}}, delta_i};
  assign sum       = subtract_i ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

  assign below_zero  = sum[SumBits-1];
  assign above_limit = sum[SumBits-2:0] > {1'b0, limit_i};

  always_comb begin
    if (below_zero) begin
      pos_o = '0;
    end else if (above_limit) begin
      pos_o = limit_i;
    end else begin
      pos_o = sum[mpct_pkg::CoordBits-1:0];
    end
  end

endmodule

// ===== rtl/mouse_packet_cursor_tracker.sv =====
// Mouse packet cursor tracker.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per read of
// the controller, carrying the status byte and the data byte. Bytes without
// both the output-full and auxiliary-data status bits are dropped. Accepted
// bytes form three-byte packets; a header byte must have bit 3 set, otherwise
// it is discarded so the stream resynchronizes.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transaction per
// completed packet with the clamped cursor position and the left button.
// The result is registered and shown the cycle after the third byte is taken.
// Throughput: one byte per cycle, held back only by the single result register:
// a byte that completes a packet waits while a previous result is stalled at
// the output; bytes that complete nothing are taken regardless of the stall.
// Configuration channel (cfg_*): registers 0..3 are x_limit, y_limit,
// x_start, y_start; writing a start register also moves the cursor there.
// Other indexes are ignored. Write only while the block is idle.
// Reset puts the limits and start positions at their defaults, places the
// cursor at the start position and waits for a header byte.
module mouse_packet_cursor_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [7:0]                     cfg_index_i,
  input  logic [mpct_pkg::CoordBits-1:0] cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mpct_pkg::in_t                  in_data_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mpct_pkg::out_t                 out_data_o
);

  localparam int unsigned CB = mpct_pkg::CoordBits;

  logic [CB-1:0] x_limit_q, x_limit_d;
  logic [CB-1:0] y_limit_q, y_limit_d;
  logic [CB-1:0] x_start_q, x_start_d;
  logic [CB-1:0] y_start_q, y_start_d;
  logic [CB-1:0] pos_x_q, pos_x_d;
  logic [CB-1:0] pos_y_q, pos_y_d;

  mpct_pkg::phase_e phase_q, phase_d;
  logic [7:0]       header_q, header_d;
  logic [7:0]       x_move_q, x_move_d;

  logic           out_valid_q, out_valid_d;
  mpct_pkg::out_t out_data_q, out_data_d;

  logic          cfg_fire;
  logic          in_fire;
  logic          byte_ok;
  logic          emit;
  logic          out_stalled;
  logic [CB-1:0] next_x;
  logic [CB-1:0] next_y;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign byte_ok = in_data_i.ctrl_status[mpct_pkg::StatusFullBit] &&
                   in_data_i.ctrl_status[mpct_pkg::StatusAuxBit];
  // Only the Y byte of a packet produces a result.
  assign emit        = byte_ok && (phase_q == mpct_pkg::PhYMove);
  assign out_stalled = out_valid_q && !out_ready_i;
  assign in_ready_o  = !(out_stalled && emit);
  assign in_fire     = in_valid_i && in_ready_o;

  mpct_axis_update u_x_update (
    .pos_i      (pos_x_q),
    .delta_i    (x_move_q),
    .sign_i     (header_q[mpct_pkg::HdrXSignBit]),
    .subtract_i (1'b0),
    .limit_i    (x_limit_q),
    .pos_o      (next_x)
  );

  mpct_axis_update u_y_update (
    .pos_i      (pos_y_q),
    .delta_i    (in_data_i.data_byte),
    .sign_i     (header_q[mpct_pkg::HdrYSignBit]),
    .subtract_i (1'b1),
    .limit_i    (y_limit_q),
    .pos_o      (next_y)
  );

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    x_move_d = x_move_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;

    if (in_fire && byte_ok) begin
      case (phase_q)
        mpct_pkg::PhXMove: begin
          x_move_d = in_data_i.data_byte;
          phase_d  = mpct_pkg::PhYMove;
        end
        mpct_pkg::PhYMove: begin
          pos_x_d = next_x;
          pos_y_d = next_y;
          phase_d = mpct_pkg::PhHeader;
        end
        default: begin
          if (in_data_i.data_byte[mpct_pkg::HdrSyncBit]) begin
            header_d = in_data_i.data_byte;
            phase_d  = mpct_pkg::PhXMove;
          end else begin
            phase_d = mpct_pkg::PhHeader;
          end
        end
      endcase
    end

    x_limit_d = x_limit_q;
    y_limit_d = y_limit_q;
    x_start_d = x_start_q;
    y_start_d = y_start_q;
    if (cfg_fire) begin
      case (mpct_pkg::cfg_idx_e'(cfg_index_i))
        mpct_pkg::CfgXLimit: x_limit_d = cfg_data_i;
        mpct_pkg::CfgYLimit: y_limit_d = cfg_data_i;
        mpct_pkg::CfgXStart: begin
          x_start_d = cfg_data_i;
          pos_x_d   = cfg_data_i;
        end
        mpct_pkg::CfgYStart: begin
          y_start_d = cfg_data_i;
          pos_y_d   = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (in_fire && emit) begin
      out_valid_d            = 1'b1;
      out_data_d.cursor_x    = next_x;
      out_data_d.cursor_y    = next_y;
      out_data_d.left_button = header_q[mpct_pkg::HdrLeftBit];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q   <= mpct_pkg::XLimitReset;
      y_limit_q   <= mpct_pkg::YLimitReset;
      x_start_q   <= mpct_pkg::XStartReset;
      y_start_q   <= mpct_pkg::YStartReset;
      pos_x_q     <= mpct_pkg::XStartReset;
      pos_y_q     <= mpct_pkg::YStartReset;
      phase_q     <= mpct_pkg::PhHeader;
      header_q    <= '0;
      x_move_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_limit_q   <= x_limit_d;
      y_limit_q   <= y_limit_d;
      x_start_q   <= x_start_d;
      y_start_q   <= y_start_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      phase_q     <= phase_d;
      header_q    <= header_d;
      x_move_q    <= x_move_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The byte phase register stays one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("byte phase is not one-hot");

  // Input back-pressure only arises from a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_ready_o |-> out_stalled)
    else $error("input stalled without a pending result");

  // A fresh result matches the tracked cursor position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && !cfg_fire) |=>
      (out_data_q.cursor_x == pos_x_q) && (out_data_q.cursor_y == pos_y_q))
    else $error("result differs from the cursor position");

  // A fresh result lies within the configured limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && !cfg_fire) |=>
      (out_data_q.cursor_x <= x_limit_q) && (out_data_q.cursor_y <= y_limit_q))
    else $error("result outside the cursor limits");

  // A completed packet always returns to waiting for a header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> (phase_q == mpct_pkg::PhHeader))
    else $error("phase did not return to header after a packet");

endmodule
